>>> design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types for the rational arithmetic unit: operation codes, controller
// states, command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Output field widths and the sign-extended intermediate width
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int EXT_W = 66;

  typedef enum logic [1:0] {
    FUNC_MUL = 2'd0,
    FUNC_ADD = 2'd1,
    FUNC_CMP = 2'd2,
    FUNC_RED = 2'd3
  } rau_func_e;

  // Product selected onto the shared multiplier
  typedef enum logic [1:0] {
    MUL_AN_BN = 2'd0,
    MUL_AN_BD = 2'd1,
    MUL_AD_BN = 2'd2,
    MUL_AD_BD = 2'd3
  } rau_mul_e;

  // Operand pair for the divider
  typedef enum logic [1:0] {
    DIV_GCD = 2'd0,
    DIV_NUM = 2'd1,
    DIV_DEN = 2'd2
  } rau_div_src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_ANBN,
    ST_M_ANBD,
    ST_M_ADBN,
    ST_M_ADBD,
    ST_SEED,
    ST_GCD_TEST,
    ST_GCD_WAIT,
    ST_DIVN_GO,
    ST_DIVN_WAIT,
    ST_DIVD_GO,
    ST_DIVD_WAIT,
    ST_DONE
  } rau_state_e;

  typedef struct packed {
    logic         load;
    logic         mul_en;
    rau_mul_e     mul_sel;
    logic         seed;
    logic         div_start;
    rau_div_src_e div_src;
    logic         rem_step;
    logic         qn_cap;
    logic         res_wr;
  } rau_cmd_t;

  typedef struct packed {
    rau_func_e func;
    logic      div_done;
    logic      x_zero;
    logic      y_zero;
  } rau_sts_t;

endpackage

>>> design/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Iterative signed divider, one quotient bit per cycle. Truncating quotient
// and a remainder that takes the sign of the dividend.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] dividend_i,
  input  logic signed [W-1:0] divisor_i,
  output logic                done_o,
  output logic signed [W:0]   quot_o,
  output logic signed [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  r_q, q_q, dm_q;
  logic          negq_q, negr_q;

  logic [W-1:0]  dd_abs, dv_abs, r_nx, q_nx;
  logic [W:0]    r_sh, qext;
  logic          ge;

  // operand magnitudes
  assign dd_abs = dividend_i[W-1] ? W'(-dividend_i) : dividend_i;
  assign dv_abs = divisor_i[W-1]  ? W'(-divisor_i)  : divisor_i;

  // restoring step
  assign r_sh = {r_q, q_q[W-1]};
  assign ge   = r_sh >= {1'b0, dm_q};
  assign r_nx = ge ? W'(r_sh - {1'b0, dm_q}) : r_sh[W-1:0];
  assign q_nx = {q_q[W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q    <= '0;
      q_q    <= dd_abs;
      dm_q   <= dv_abs;
      negq_q <= dividend_i[W-1] ^ divisor_i[W-1];
      negr_q <= dividend_i[W-1];
    end else if (busy_q) begin
      r_q <= r_nx;
      q_q <= q_nx;
    end
  end

  assign qext   = {1'b0, q_q};
  assign quot_o = negq_q ? $signed((W+1)'(0) - qext) : $signed(qext);
  assign rem_o  = negr_q ? $signed(W'(0) - r_q) : $signed(r_q);
  assign done_o = done_q;

endmodule

>>> design/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shared multiplier, Euclid registers, divider and the
// result register.
// ----------------------------------------------------------------------------
module rau_datapath #(
  parameter int OB = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rau_pkg::rau_cmd_t             cmd_i,
  output rau_pkg::rau_sts_t             sts_o,
  input  logic [1:0]                    func_i,
  input  logic signed [OB-1:0]          a_num_i,
  input  logic signed [OB-1:0]          a_den_i,
  input  logic signed [OB-1:0]          b_num_i,
  input  logic signed [OB-1:0]          b_den_i,
  output logic signed [rau_pkg::NUM_W-1:0] res_num_o,
  output logic signed [rau_pkg::DEN_W-1:0] res_den_o,
  output logic                          equivalent_o,
  output logic                          zero_gcd_error_o
);

  localparam int PW = 2 * OB;

  logic [1:0]           func_q;
  logic signed [OB-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [OB-1:0] x_q, y_q;
  logic signed [PW-1:0] anbn_q, anbd_q, adbn_q, adbd_q;
  logic signed [OB:0]   qn_q;

  logic signed [OB-1:0] ma, mb, dv_a, dv_b;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   sum;
  logic                 div_done;
  logic signed [OB:0]   div_q;
  logic signed [OB-1:0] div_r;

  logic signed [rau_pkg::EXT_W-1:0] n_ext, d_ext;
  logic                             eq_d, err_d;

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      rau_pkg::MUL_AN_BN: begin ma = an_q; mb = bn_q; end
      rau_pkg::MUL_AN_BD: begin ma = an_q; mb = bd_q; end
      rau_pkg::MUL_AD_BN: begin ma = ad_q; mb = bn_q; end
      rau_pkg::MUL_AD_BD: begin ma = ad_q; mb = bd_q; end
      default:            begin ma = an_q; mb = bn_q; end
    endcase
  end

  assign prod = PW'(ma) * PW'(mb);
  assign sum  = (PW+1)'(anbd_q) + (PW+1)'(adbn_q);

  // divider operand select
  always_comb begin
    case (cmd_i.div_src)
      rau_pkg::DIV_GCD: begin dv_a = x_q;  dv_b = y_q; end
      rau_pkg::DIV_NUM: begin dv_a = an_q; dv_b = x_q; end
      rau_pkg::DIV_DEN: begin dv_a = ad_q; dv_b = x_q; end
      default:          begin dv_a = x_q;  dv_b = y_q; end
    endcase
  end

  rau_div #(.W(OB)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dv_a),
    .divisor_i  (dv_b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // result select, sign-extended then cut to field widths
  always_comb begin
    n_ext = '0;
    d_ext = '0;
    eq_d  = 1'b0;
    err_d = 1'b0;
    case (rau_pkg::rau_func_e'(func_q))
      rau_pkg::FUNC_MUL: begin
        n_ext = rau_pkg::EXT_W'(anbn_q);
        d_ext = rau_pkg::EXT_W'(adbd_q);
      end
      rau_pkg::FUNC_ADD: begin
        n_ext = rau_pkg::EXT_W'(sum);
        d_ext = rau_pkg::EXT_W'(adbd_q);
      end
      rau_pkg::FUNC_CMP: begin
        eq_d = (anbd_q == adbn_q);
      end
      rau_pkg::FUNC_RED: begin
        if (x_q == '0) begin
          err_d = 1'b1;
          n_ext = rau_pkg::EXT_W'(an_q);
          d_ext = rau_pkg::EXT_W'(ad_q);
        end else begin
          n_ext = rau_pkg::EXT_W'(qn_q);
          d_ext = rau_pkg::EXT_W'(div_q);
        end
      end
      default: begin
        eq_d = 1'b0;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      an_q   <= a_num_i;
      ad_q   <= a_den_i;
      bn_q   <= b_num_i;
      bd_q   <= b_den_i;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        rau_pkg::MUL_AN_BN: anbn_q <= prod;
        rau_pkg::MUL_AN_BD: anbd_q <= prod;
        rau_pkg::MUL_AD_BN: adbn_q <= prod;
        rau_pkg::MUL_AD_BD: adbd_q <= prod;
        default:            anbn_q <= prod;
      endcase
    end
    // Euclid seed: larger of the two parts goes first
    if (cmd_i.seed) begin
      if (an_q > ad_q) begin
        x_q <= an_q;
        y_q <= ad_q;
      end else begin
        x_q <= ad_q;
        y_q <= an_q;
      end
    end else if (cmd_i.rem_step) begin
      x_q <= y_q;
      y_q <= div_r;
    end
    if (cmd_i.qn_cap) begin
      qn_q <= div_q;
    end
    if (cmd_i.res_wr) begin
      res_num_o        <= n_ext[rau_pkg::NUM_W-1:0];
      res_den_o        <= d_ext[rau_pkg::DEN_W-1:0];
      equivalent_o     <= eq_d;
      zero_gcd_error_o <= err_d;
    end
  end

  assign sts_o.func     = rau_pkg::rau_func_e'(func_q);
  assign sts_o.div_done = div_done;
  assign sts_o.x_zero   = (x_q == '0);
  assign sts_o.y_zero   = (y_q == '0);

endmodule

>>> design/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for the rational unit: issues multiplies, runs the Euclid loop
// and the final divisions, and owns both handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rau_pkg::rau_cmd_t cmd_o,
  input  rau_pkg::rau_sts_t sts_i
);

  rau_pkg::rau_state_e state_q, state_d;
  logic                out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.res_wr) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = rau_pkg::MUL_AN_BN;
    cmd_o.div_src = rau_pkg::DIV_GCD;
    case (state_q)
      rau_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (rau_pkg::rau_func_e'(func_i))
            rau_pkg::FUNC_MUL: state_d = rau_pkg::ST_M_ANBN;
            rau_pkg::FUNC_ADD: state_d = rau_pkg::ST_M_ANBD;
            rau_pkg::FUNC_CMP: state_d = rau_pkg::ST_M_ANBD;
            default:           state_d = rau_pkg::ST_SEED;
          endcase
        end
      end
      rau_pkg::ST_M_ANBN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MUL_AN_BN;
        state_d       = rau_pkg::ST_M_ADBD;
      end
      rau_pkg::ST_M_ANBD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MUL_AN_BD;
        state_d       = rau_pkg::ST_M_ADBN;
      end
      rau_pkg::ST_M_ADBN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MUL_AD_BN;
        state_d       = (sts_i.func == rau_pkg::FUNC_ADD) ? rau_pkg::ST_M_ADBD
                                                          : rau_pkg::ST_DONE;
      end
      rau_pkg::ST_M_ADBD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MUL_AD_BD;
        state_d       = rau_pkg::ST_DONE;
      end
      rau_pkg::ST_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = rau_pkg::ST_GCD_TEST;
      end
      // Euclid loop: stop when the remainder reaches zero
      rau_pkg::ST_GCD_TEST: begin
        if (sts_i.y_zero) begin
          state_d = sts_i.x_zero ? rau_pkg::ST_DONE : rau_pkg::ST_DIVN_GO;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = rau_pkg::DIV_GCD;
          state_d         = rau_pkg::ST_GCD_WAIT;
        end
      end
      rau_pkg::ST_GCD_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.rem_step = 1'b1;
          state_d        = rau_pkg::ST_GCD_TEST;
        end
      end
      rau_pkg::ST_DIVN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = rau_pkg::DIV_NUM;
        state_d         = rau_pkg::ST_DIVN_WAIT;
      end
      rau_pkg::ST_DIVN_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.qn_cap = 1'b1;
          state_d      = rau_pkg::ST_DIVD_GO;
        end
      end
      rau_pkg::ST_DIVD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = rau_pkg::DIV_DEN;
        state_d         = rau_pkg::ST_DIVD_WAIT;
      end
      rau_pkg::ST_DIVD_WAIT: begin
        if (sts_i.div_done) begin
          state_d = rau_pkg::ST_DONE;
        end
      end
      rau_pkg::ST_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.res_wr = 1'b1;
          state_d      = rau_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rau_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != rau_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_wr |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // an accepted item always starts work
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != rau_pkg::ST_IDLE))
    else $error("accepted item dropped");

  // divider completes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == rau_pkg::ST_GCD_WAIT ||
                        state_q == rau_pkg::ST_DIVN_WAIT ||
                        state_q == rau_pkg::ST_DIVD_WAIT))
    else $error("divider done outside wait state");
`endif

endmodule

>>> design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational ALU: multiply, add, cross-product compare and GCD reduction.
// ----------------------------------------------------------------------------
// One item at a time. With the output free, multiply steps through the
// an*bn and ad*bd products, compare through an*bd and ad*bn, and add through
// an*bd, ad*bn and ad*bd before the result register loads in the done state,
// all on one shared OPERAND_BITS by OPERAND_BITS multiplier.
// Reduce runs the Euclid remainder steps and then the two final divisions;
// each runs on one bit-serial divider, one quotient bit per cycle.
// A finished result waits in the output register while the next item is
// taken in.
module rational_arithmetic_unit #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           func_i,
  input  logic signed [OPERAND_BITS-1:0]       a_num_i,
  input  logic signed [OPERAND_BITS-1:0]       a_den_i,
  input  logic signed [OPERAND_BITS-1:0]       b_num_i,
  input  logic signed [OPERAND_BITS-1:0]       b_den_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rau_pkg::NUM_W-1:0]     res_num_o,
  output logic signed [rau_pkg::DEN_W-1:0]     res_den_o,
  output logic                                 equivalent_o,
  output logic                                 zero_gcd_error_o
);

  rau_pkg::rau_cmd_t cmd;
  rau_pkg::rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rau_datapath #(.OB(OPERAND_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (func_i),
    .a_num_i          (a_num_i),
    .a_den_i          (a_den_i),
    .b_num_i          (b_num_i),
    .b_den_i          (b_den_i),
    .res_num_o        (res_num_o),
    .res_den_o        (res_den_o),
    .equivalent_o     (equivalent_o),
    .zero_gcd_error_o (zero_gcd_error_o)
  );

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational arithmetic unit. A queue of operand
// items feeds a valid/stall driver; a monitor compares every result with an
// in-bench prediction of multiply, add, cross-product compare and GCD reduce.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OB = 16;

  typedef struct {
    rau_pkg::rau_func_e func;
    logic [OB-1:0]      a_num;
    logic [OB-1:0]      a_den;
    logic [OB-1:0]      b_num;
    logic [OB-1:0]      b_den;
  } rat_item_t;

  typedef struct {
    logic [rau_pkg::NUM_W-1:0] num;
    logic [rau_pkg::DEN_W-1:0] den;
    logic                      eq;
    logic                      err;
  } rat_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = '0;
  logic signed [OB-1:0] a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [rau_pkg::NUM_W-1:0] res_num_o;
  logic signed [rau_pkg::DEN_W-1:0] res_den_o;
  logic equivalent_o, zero_gcd_error_o;

  rat_item_t pending_items[$];
  rat_res_t  expected_results[$];
  int        mismatches = 0;
  int        accepted_items = 0;
  int        total_items = 0;
  bit        calm_stretch = 1'b0;

  rational_arithmetic_unit #(.OPERAND_BITS(OB)) u_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Euclid GCD seeded by the larger part, truncating remainder
  function automatic longint rat_gcd(longint n, longint d);
    longint x, y, t;
    if (n > d) begin
      x = n; y = d;
    end else begin
      x = d; y = n;
    end
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    return x;
  endfunction

  function automatic rat_res_t predict_rational(rat_item_t it);
    rat_res_t r;
    longint an, ad, bn, bd, g;
    an = longint'($signed(it.a_num));
    ad = longint'($signed(it.a_den));
    bn = longint'($signed(it.b_num));
    bd = longint'($signed(it.b_den));
    r = '{default: '0};
    case (it.func)
      rau_pkg::FUNC_MUL: begin
        r.num = rau_pkg::NUM_W'(an * bn);
        r.den = rau_pkg::DEN_W'(ad * bd);
      end
      rau_pkg::FUNC_ADD: begin
        r.num = rau_pkg::NUM_W'(bd * an + ad * bn);
        r.den = rau_pkg::DEN_W'(ad * bd);
      end
      rau_pkg::FUNC_CMP: r.eq = (an * bd == bn * ad);
      default: begin
        g = rat_gcd(an, ad);
        if (g == 0) begin
          r.err = 1'b1;
          r.num = rau_pkg::NUM_W'(an);
          r.den = rau_pkg::DEN_W'(ad);
        end else begin
          r.num = rau_pkg::NUM_W'(an / g);
          r.den = rau_pkg::DEN_W'(ad / g);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [OB-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return OB'($urandom_range(0, 2)) - 16'd1;
      3: return OB'($signed($urandom_range(0, 40)) - 20);
      default: return OB'($urandom);
    endcase
  endfunction

  task automatic add_item(rau_pkg::rau_func_e f, int an, int ad, int bn, int bd);
    rat_item_t it;
    it.func = f;
    it.a_num = OB'(an); it.a_den = OB'(ad);
    it.b_num = OB'(bn); it.b_den = OB'(bd);
    pending_items.push_back(it);
  endtask

  // Stimulus: directed corners, then random items
  initial begin
    rat_item_t it;
    add_item(rau_pkg::FUNC_MUL, -32768, -32768, -32768, -32768);
    add_item(rau_pkg::FUNC_MUL, 32767, -1, 32767, 32767);
    add_item(rau_pkg::FUNC_ADD, -32768, -32768, -32768, -32768);
    add_item(rau_pkg::FUNC_ADD, 32767, 32767, 32767, 32767);
    add_item(rau_pkg::FUNC_ADD, 3, 0, 5, 0);
    add_item(rau_pkg::FUNC_CMP, 1, 2, 2, 4);
    add_item(rau_pkg::FUNC_CMP, 1, 2, 2, 5);
    add_item(rau_pkg::FUNC_CMP, 0, 0, 7, 0);
    add_item(rau_pkg::FUNC_CMP, -32768, 32767, 32767, -32768);
    add_item(rau_pkg::FUNC_RED, 0, 0, 0, 0);
    add_item(rau_pkg::FUNC_RED, 12, 18, 0, 0);
    add_item(rau_pkg::FUNC_RED, 18, 12, -1, -1);
    add_item(rau_pkg::FUNC_RED, -12, 18, 0, 0);
    add_item(rau_pkg::FUNC_RED, 12, -18, 0, 0);
    add_item(rau_pkg::FUNC_RED, -32768, -32768, 0, 0);
    add_item(rau_pkg::FUNC_RED, 32767, -32768, 0, 0);
    add_item(rau_pkg::FUNC_RED, 0, 5, 0, 0);
    add_item(rau_pkg::FUNC_RED, 7, 0, 0, 0);
    add_item(rau_pkg::FUNC_RED, 28657, 17711, 0, 0);
    add_item(rau_pkg::FUNC_RED, -32768, 1, 0, 0);
    for (int i = 0; i < 1250; i++) begin
      it.func = rau_pkg::rau_func_e'($urandom_range(0, 3));
      it.a_num = rand_operand(); it.a_den = rand_operand();
      it.b_num = rand_operand(); it.b_den = rand_operand();
      // equal ratios now and then so compare hits true
      if (it.func == rau_pkg::FUNC_CMP && $urandom_range(0, 1)) begin
        it.b_num = OB'($signed(it.a_num) * 2);
        it.b_den = OB'($signed(it.a_den) * 2);
      end
      pending_items.push_back(it);
    end
    total_items = pending_items.size();
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Calm stretch: no idling on either side for a while mid-run
  always @(posedge clk_i) begin
    calm_stretch <= (accepted_items >= 400 && accepted_items < 550);
  end

  // Driver; after item 700 the sender waits until every result has drained
  always @(posedge clk_i) begin
    int sent;
    if (rst_ni) begin
      sent = accepted_items;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_rational(pending_items.pop_front()));
        sent = sent + 1;
        accepted_items <= sent;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_items.size() != 0
            && !(sent == 700 && expected_results.size() != 0)
            && (calm_stretch || sent == 700 || $urandom_range(0, 99) >= 36)) begin
          in_valid_i <= 1'b1;
          func_i  <= pending_items[0].func;
          a_num_i <= pending_items[0].a_num;
          a_den_i <= pending_items[0].a_den;
          b_num_i <= pending_items[0].b_num;
          b_den_i <= pending_items[0].b_den;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    rat_res_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result num=%h", res_num_o);
        end else begin
          exp_r = expected_results.pop_front();
          if (res_num_o !== exp_r.num || res_den_o !== exp_r.den ||
              equivalent_o !== exp_r.eq || zero_gcd_error_o !== exp_r.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp num=%h den=%h eq=%b err=%b, got %h %h %b %b",
                       exp_r.num, exp_r.den, exp_r.eq, exp_r.err,
                       res_num_o, res_den_o, equivalent_o, zero_gcd_error_o);
          end
        end
      end
      out_stall_i <= calm_stretch ? 1'b0 : ($urandom_range(0, 99) < 36);
    end
  end

  // End of run
  initial begin
    wait (rst_ni && total_items != 0);
    wait (accepted_items == total_items && expected_results.size() == 0);
    repeat (1000) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("** rational_arithmetic_unit: PASSED **");
    else
      $display("** rational_arithmetic_unit: FAILED **");
    $finish;
  end

  initial begin
    #60000000;
    $display("** rational_arithmetic_unit: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
design/rau_pkg.sv
design/rau_div.sv
design/rau_datapath.sv
design/rau_ctrl.sv
design/rational_arithmetic_unit.sv
dv/tb_top.sv
